>>> design/byte_stack_with_palindrome_check_unit_defines.svh
// Assertion helpers used by the stack unit design file.
`ifndef BYTE_STACK_WITH_PALINDROME_CHECK_UNIT_DEFINES_SVH
`define BYTE_STACK_WITH_PALINDROME_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSPC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("stack assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define BSPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("stack assertion failed: next-cycle check");

`endif

>>> design/bspc_pkg.sv
package bspc_pkg;

    // Operation codes on s_kind
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;

    localparam int DATA_W  = 8;
    localparam int FILL_W  = 7;

    // One result transaction
    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] pop_value;
        logic              is_palindrome;
        logic [FILL_W-1:0] fill_count;
    } result_t;

endpackage

>>> design/byte_stack_with_palindrome_check_unit.sv
// Byte stack with palindrome check.
// Input channel (s_valid/s_ready): s_kind selects push, pop or palindrome
// query; s_push_value is the byte stored by a push. Every input transaction
// gives exactly one result transaction on m_valid/m_ready carrying status,
// the popped byte, the palindrome flag and the fill count after the op.
// Push, overflow, empty pop, unknown kind and a query on fewer than two
// entries show their result in the cycle after acceptance. A pop reads the
// entry RAM, then loads the result register once the output is free. A
// query on n >= 2 entries walks one mirrored entry pair per cycle through
// the two read ports of the entry RAM; the walk length sets the throughput.
// One transaction is worked on at a time; a new one is taken only when the
// unit is idle and the result register is free or being drained.
// Reset (aresetn low, synchronous) empties the stack and drops any pending
// result; entry contents are not cleared and need no clearing pass.
// When the receiver stalls, the result is held in the output register and
// s_ready stays low until it is taken.
`include "byte_stack_with_palindrome_check_unit_defines.svh"

module byte_stack_with_palindrome_check_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_push_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_pop_value,
    output logic       m_is_palindrome,
    output logic [6:0] m_fill_count
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_PAL  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     lo_reg, lo_next;
    logic [AW-1:0]     hi_reg, hi_next;
    logic              miss_reg, miss_next;
    logic              m_valid_reg, m_valid_next;
    bspc_pkg::result_t res_reg, res_next;

    logic          out_free;
    logic          accept;
    logic          push_room;
    logic [CW-1:0] count_inc;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr_a;
    logic [AW-1:0] ram_rd_addr_b;
    logic [7:0]    ram_rd_data_a;
    logic [7:0]    ram_rd_data_b;

    bspc_ram #(
        .WIDTH (bspc_pkg::DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_entry_ram (
        .aclk      (aclk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (s_push_value),
        .rd_en     (ram_rd_en),
        .rd_addr_a (ram_rd_addr_a),
        .rd_addr_b (ram_rd_addr_b),
        .rd_data_a (ram_rd_data_a),
        .rd_data_b (ram_rd_data_b)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    // Push that finds room on the stack
    assign push_room = accept && (s_kind == bspc_pkg::KIND_PUSH) &&
                       (count_reg < CW'(STACK_DEPTH));
    assign count_inc = count_reg + CW'(1);

    // Sequencer: decode, RAM access, pair walk, result load
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        miss_next     = miss_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        res_next      = res_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = AW'(count_reg);
        ram_rd_en     = 1'b0;
        ram_rd_addr_a = lo_reg;
        ram_rd_addr_b = hi_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next.status        = bspc_pkg::STATUS_OK;
                    res_next.pop_value     = '0;
                    res_next.is_palindrome = 1'b0;
                    res_next.fill_count    = bspc_pkg::FILL_W'(count_reg);
                    case (s_kind)
                        bspc_pkg::KIND_PUSH: begin
                            m_valid_next = 1'b1;
                            if (count_reg == CW'(STACK_DEPTH)) begin
                                res_next.status = bspc_pkg::STATUS_OVERFLOW;
                            end else begin
                                ram_wr_en           = 1'b1;
                                count_next          = count_reg + CW'(1);
                                res_next.fill_count =
                                    bspc_pkg::FILL_W'(count_reg + CW'(1));
                            end
                        end
                        bspc_pkg::KIND_POP: begin
                            if (count_reg == '0) begin
                                m_valid_next    = 1'b1;
                                res_next.status = bspc_pkg::STATUS_EMPTY;
                            end else begin
                                count_next    = count_reg - CW'(1);
                                ram_rd_en     = 1'b1;
                                ram_rd_addr_a = AW'(count_reg - CW'(1));
                                state_next    = ST_POP;
                            end
                        end
                        bspc_pkg::KIND_QUERY: begin
                            if (count_reg < CW'(2)) begin
                                m_valid_next           = 1'b1;
                                res_next.is_palindrome = 1'b1;
                            end else begin
                                ram_rd_en     = 1'b1;
                                ram_rd_addr_a = '0;
                                ram_rd_addr_b = AW'(count_reg - CW'(1));
                                lo_next       = AW'(1);
                                hi_next       = AW'(count_reg - CW'(2));
                                miss_next     = 1'b0;
                                state_next    = ST_PAL;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                // Read data of the popped entry is held until the output frees
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    res_next.status        = bspc_pkg::STATUS_OK;
                    res_next.pop_value     = ram_rd_data_a;
                    res_next.is_palindrome = 1'b0;
                    res_next.fill_count    = bspc_pkg::FILL_W'(count_reg);
                    state_next             = ST_IDLE;
                end
            end
            ST_PAL: begin
                // Compare the pair read last cycle, issue the next inner pair
                miss_next = miss_reg || (ram_rd_data_a != ram_rd_data_b);
                if (lo_reg < hi_reg) begin
                    ram_rd_en = 1'b1;
                    lo_next   = lo_reg + AW'(1);
                    hi_next   = hi_reg - AW'(1);
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    res_next.status        = bspc_pkg::STATUS_OK;
                    res_next.pop_value     = '0;
                    res_next.is_palindrome = !miss_reg;
                    res_next.fill_count    = bspc_pkg::FILL_W'(count_reg);
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Walk indexes and result payload
    always_ff @(posedge aclk) begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        miss_reg <= miss_next;
        res_reg  <= res_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = res_reg.status;
    assign m_pop_value     = res_reg.pop_value;
    assign m_is_palindrome = res_reg.is_palindrome;
    assign m_fill_count    = res_reg.fill_count;

    // Checks
    `BSPC_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(STACK_DEPTH))
    `BSPC_ASSERT_SAME(a_ready_only_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE)
    `BSPC_ASSERT_NEXT(a_push_grows, aclk, aresetn, push_room, (count_reg == $past(count_inc)) && m_valid_reg)
    `BSPC_ASSERT_SAME(a_walk_order, aclk, aresetn, state_reg == ST_PAL, lo_reg <= hi_reg + AW'(1))

endmodule

>>> design/bspc_ram.sv
// Simple RAM: one write port, two read ports, registered read data.
module bspc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read ports; data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= mem_reg[rd_addr_a];
            rd_data_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule
